/* src/cedf_pkg.sv */
`timescale 1ns / 1ps

package cedf_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int TAG_BITS    = 8;

    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [IDX_W:0] SCAN_END = (IDX_W + 1)'(QUEUE_DEPTH);

    localparam logic [2:0] CLS_HI_LAST_DLY = 3'd0;
    localparam logic [2:0] CLS_HI_LAST     = 3'd1;
    localparam logic [2:0] CLS_HI_DLY      = 3'd2;
    localparam logic [2:0] CLS_HI_OTHER    = 3'd3;
    localparam logic [2:0] CLS_LO_LAST_DLY = 3'd4;
    localparam logic [2:0] CLS_LO_DLY      = 3'd5;
    localparam logic [2:0] CLS_LO_LAST     = 3'd6;
    localparam logic [2:0] CLS_LO_OTHER    = 3'd7;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_FIN_NONE = 2'd2;

    typedef struct packed {
        logic [2:0]  cls;
        logic [31:0] deadline;
    } key_t;

    typedef struct packed {
        key_t                key;
        logic [TAG_BITS-1:0] tag;
    } entry_t;

    typedef struct packed {
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        logic             clr_en;
        logic [IDX_W-1:0] clr_addr;
    } store_ctl_t;

    typedef struct packed {
        logic lt;
        logic eq;
    } cmp_res_t;

    function automatic logic [2:0] class_of(input logic hi, input logic last,
                                            input logic dly);
        logic [2:0] cls;
        if (hi)
        begin
            if (last && dly)
                cls = CLS_HI_LAST_DLY;
            else if (last)
                cls = CLS_HI_LAST;
            else if (dly)
                cls = CLS_HI_DLY;
            else
                cls = CLS_HI_OTHER;
        end
        else
        begin
            if (last && dly)
                cls = CLS_LO_LAST_DLY;
            else if (dly)
                cls = CLS_LO_DLY;
            else if (last)
                cls = CLS_LO_LAST;
            else
                cls = CLS_LO_OTHER;
        end
        return cls;
    endfunction

endpackage

/* src/cedf_cmp.sv */
`timescale 1ns / 1ps

module cedf_cmp
    import cedf_pkg::*;
(
    input  key_t     a,
    input  key_t     b,
    output cmp_res_t res
);

    // class is the major field, deadline the minor one
    assign res.lt = a < b;
    assign res.eq = a == b;

endmodule

/* src/cedf_store.sv */
`timescale 1ns / 1ps

module cedf_store
    import cedf_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  store_ctl_t       ctl,
    input  entry_t           wr_data,
    output entry_t           rd_data,
    output logic             rd_valid,
    output logic [CNT_W-1:0] count
);

    entry_t                  mem [QUEUE_DEPTH];
    entry_t                  rd_data_reg;
    logic                    rd_valid_reg;
    logic [QUEUE_DEPTH-1:0]  valid_reg;
    logic [QUEUE_DEPTH-1:0]  valid_next;
    logic [CNT_W-1:0]        count_reg;
    logic [CNT_W-1:0]        count_next;

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
            mem[ctl.wr_addr] <= wr_data;
        if (ctl.rd_en)
            rd_data_reg <= mem[ctl.rd_addr];
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (ctl.wr_en)
            valid_next[ctl.wr_addr] = 1'b1;
        if (ctl.clr_en)
            valid_next[ctl.clr_addr] = 1'b0;
        count_next = CNT_W'(count_reg + CNT_W'(ctl.wr_en) - CNT_W'(ctl.clr_en));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
            count_reg    <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            count_reg <= count_next;
            if (ctl.rd_en)
                rd_valid_reg <= valid_reg[ctl.rd_addr];
        end
    end

    assign rd_data  = rd_data_reg;
    assign rd_valid = rd_valid_reg;
    assign count    = count_reg;

endmodule

/* src/class_edf_admission_scheduler_core.sv */
`timescale 1ns / 1ps

// Admission scheduler: releases are granted at once when a run slot is free
// and nothing waits, else filed in a QUEUE_DEPTH-entry waiting store; the
// head (best class, then earliest deadline, then lowest slot) is granted
// whenever a slot frees. For every event, release or finish, one shared key
// comparator walks the waiting store one entry per cycle through its single
// registered read port, then the decision state commits the store update and
// loads the result register. A result waiting on out_stall does not block
// acceptance of the next event; it delays only that event's decision state.
// A release that finds the store full is neither granted nor filed (ST_FULL).
// max_running resets to 1 and is written at any byte address from 0 to 3.
module class_edf_admission_scheduler_core
    import cedf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic        cmd,
    input  logic [7:0]  op_id,
    input  logic        high_priority,
    input  logic        is_last,
    input  logic        prior_delayed,
    input  logic [31:0] deadline,

    output logic        out_valid,
    input  logic        out_stall,
    output logic        grant_valid,
    output logic [7:0]  grant_id,
    output logic [1:0]  status,
    output logic [4:0]  queued_count
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_DECIDE = 2'd2;

    localparam logic [IDX_W:0] ADDR_ZERO = '0;
    localparam logic [IDX_W:0] ADDR_ONE  = (IDX_W + 1)'(1);

    logic [1:0]          state_reg, state_next;
    logic [5:0]          max_run_reg;
    logic [5:0]          run_reg, run_next;

    logic                cmd_reg, cmd_next;
    logic [TAG_BITS-1:0] tag_reg, tag_next;
    key_t                new_key_reg, new_key_next;

    logic [IDX_W:0]      addr_reg, addr_next;
    logic                issue_reg, issue_next;
    logic [IDX_W-1:0]    rd_idx_reg, rd_idx_next;

    logic                best_found_reg, best_found_next;
    logic [IDX_W-1:0]    best_idx_reg, best_idx_next;
    key_t                best_key_reg, best_key_next;
    logic [TAG_BITS-1:0] best_tag_reg, best_tag_next;
    logic                free_found_reg, free_found_next;
    logic [IDX_W-1:0]    free_idx_reg, free_idx_next;

    logic                out_valid_reg, out_valid_next;
    logic                grant_valid_reg, grant_valid_next;
    logic [7:0]          grant_id_reg, grant_id_next;
    logic [1:0]          status_reg, status_next;
    logic [4:0]          queued_reg, queued_next;

    store_ctl_t          ctl;
    entry_t              wr_data;
    entry_t              rd_data;
    logic                rd_valid;
    logic [CNT_W-1:0]    count;

    key_t                cmp_a;
    cmp_res_t            cmp_res;

    logic                out_free;
    logic                rel;
    logic                direct;
    logic [5:0]          run1;
    logic                insert_cand;
    logic                new_better;
    logic                head_grant;
    logic                do_insert;
    logic                do_remove;
    logic                cfg_wr;

    // config port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == 1'b0);
    assign prdata = (paddr[2] == 1'b0) ? {26'd0, max_run_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            max_run_reg <= 6'd1;
        else if (cfg_wr)
            max_run_reg <= pwdata[5:0];
    end

    cedf_store u_store
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl),
        .wr_data  (wr_data),
        .rd_data  (rd_data),
        .rd_valid (rd_valid),
        .count    (count)
    );

    // shared comparator: scan entry vs best, then new item vs best
    assign cmp_a = (state_reg == S_DECIDE) ? new_key_reg : rd_data.key;

    cedf_cmp u_cmp
    (
        .a   (cmp_a),
        .b   (best_key_reg),
        .res (cmp_res)
    );

    assign in_stall = (state_reg != S_IDLE);
    assign out_free = !out_valid_reg || !out_stall;

    // decision terms
    assign rel         = !cmd_reg;
    assign direct      = rel && (run_reg < max_run_reg) && (count == '0);
    assign insert_cand = rel && !direct && free_found_reg;
    assign new_better  = insert_cand && (!best_found_reg || cmp_res.lt ||
                         (cmp_res.eq && (free_idx_reg < best_idx_reg)));
    assign head_grant  = !direct && (run1 < max_run_reg) &&
                         (best_found_reg || insert_cand);
    assign do_insert   = insert_cand && !(head_grant && new_better);
    assign do_remove   = head_grant && !new_better;

    always_comb
    begin
        if (direct)
            run1 = run_reg + 6'd1;
        else if (cmd_reg && (run_reg != 6'd0))
            run1 = run_reg - 6'd1;
        else
            run1 = run_reg;
    end

    assign wr_data.key = new_key_reg;
    assign wr_data.tag = tag_reg;

    always_comb
    begin
        state_next       = state_reg;
        run_next         = run_reg;
        cmd_next         = cmd_reg;
        tag_next         = tag_reg;
        new_key_next     = new_key_reg;
        addr_next        = addr_reg;
        issue_next       = issue_reg;
        rd_idx_next      = rd_idx_reg;
        best_found_next  = best_found_reg;
        best_idx_next    = best_idx_reg;
        best_key_next    = best_key_reg;
        best_tag_next    = best_tag_reg;
        free_found_next  = free_found_reg;
        free_idx_next    = free_idx_reg;
        out_valid_next   = out_valid_reg && out_stall;
        grant_valid_next = grant_valid_reg;
        grant_id_next    = grant_id_reg;
        status_next      = status_reg;
        queued_next      = queued_reg;
        ctl              = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next         = cmd;
                    tag_next         = TAG_BITS'(op_id);
                    new_key_next.cls = class_of(high_priority, is_last, prior_delayed);
                    new_key_next.deadline = deadline;
                    addr_next        = ADDR_ZERO;
                    issue_next       = 1'b0;
                    best_found_next  = 1'b0;
                    free_found_next  = 1'b0;
                    state_next       = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (addr_reg < SCAN_END)
                begin
                    ctl.rd_en   = 1'b1;
                    ctl.rd_addr = addr_reg[IDX_W-1:0];
                    addr_next   = addr_reg + ADDR_ONE;
                    rd_idx_next = addr_reg[IDX_W-1:0];
                    issue_next  = 1'b1;
                end
                else
                begin
                    issue_next = 1'b0;
                end
                if (issue_reg)
                begin
                    if (rd_valid)
                    begin
                        if (!best_found_reg || cmp_res.lt)
                        begin
                            best_found_next = 1'b1;
                            best_idx_next   = rd_idx_reg;
                            best_key_next   = rd_data.key;
                            best_tag_next   = rd_data.tag;
                        end
                    end
                    else if (!free_found_reg)
                    begin
                        free_found_next = 1'b1;
                        free_idx_next   = rd_idx_reg;
                    end
                end
                if (addr_reg == SCAN_END)
                    state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                if (out_free)
                begin
                    ctl.wr_en    = do_insert;
                    ctl.wr_addr  = free_idx_reg;
                    ctl.clr_en   = do_remove;
                    ctl.clr_addr = best_idx_reg;
                    run_next     = head_grant ? run1 + 6'd1 : run1;

                    out_valid_next   = 1'b1;
                    grant_valid_next = direct || head_grant;
                    if (direct || (head_grant && new_better))
                        grant_id_next = 8'(tag_reg);
                    else if (head_grant)
                        grant_id_next = 8'(best_tag_reg);
                    else
                        grant_id_next = 8'd0;

                    if (cmd_reg && (run_reg == 6'd0))
                        status_next = ST_FIN_NONE;
                    else if (rel && !direct && !free_found_reg)
                        status_next = ST_FULL;
                    else
                        status_next = ST_OK;

                    queued_next = 5'(count + CNT_W'(do_insert) - CNT_W'(do_remove));
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            run_reg       <= 6'd0;
            issue_reg     <= 1'b0;
            addr_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            run_reg       <= run_next;
            issue_reg     <= issue_next;
            addr_reg      <= addr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg         <= cmd_next;
        tag_reg         <= tag_next;
        new_key_reg     <= new_key_next;
        rd_idx_reg      <= rd_idx_next;
        best_found_reg  <= best_found_next;
        best_idx_reg    <= best_idx_next;
        best_key_reg    <= best_key_next;
        best_tag_reg    <= best_tag_next;
        free_found_reg  <= free_found_next;
        free_idx_reg    <= free_idx_next;
        grant_valid_reg <= grant_valid_next;
        grant_id_reg    <= grant_id_next;
        status_reg      <= status_next;
        queued_reg      <= queued_next;
    end

    assign out_valid    = out_valid_reg;
    assign grant_valid  = grant_valid_reg;
    assign grant_id     = grant_id_reg;
    assign status       = status_reg;
    assign queued_count = queued_reg;

endmodule

/* src/cedf_checker.sv */
`timescale 1ns / 1ps

module cedf_checker
    import cedf_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic       out_valid,
    input logic       out_stall,
    input logic       grant_valid,
    input logic [7:0] grant_id,
    input logic [1:0] status,
    input logic [4:0] queued_count
);

    // a held result beat stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result beat dropped while stalled");

    // the block is busy right after taking an event
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("event accepted back to back");

    a_no_grant_zero_id: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !grant_valid |-> grant_id == 8'd0)
        else $error("nonzero tag without grant");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status != 2'd3)
        else $error("undefined status code");

    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> {27'd0, queued_count} <= 32'(QUEUE_DEPTH))
        else $error("waiting count above store depth");

endmodule

bind class_edf_admission_scheduler_core cedf_checker u_cedf_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .grant_valid  (grant_valid),
    .grant_id     (grant_id),
    .status       (status),
    .queued_count (queued_count)
);

/* tb/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
    import cedf_pkg::*;

    localparam logic       CMD_RELEASE      = 1'b0;
    localparam logic       CMD_FINISH       = 1'b1;
    localparam logic [2:0] ADDR_MAX_RUNNING = 3'd0;
    localparam int         CYCLE_LIMIT      = 1_000_000;
    localparam int         RANDOM_PHASES    = 10;
    localparam int         PHASE_ITEMS      = 90;
    localparam int         SLOT_PLAN [RANDOM_PHASES] = '{32, 0, 2, 63, 1, 5, 0, 32, 3, 1};

    typedef struct packed {
        logic       grant_valid;
        logic [7:0] grant_id;
        logic [1:0] status;
        logic [4:0] queued_count;
    } grant_rec_t;

    class grant_scoreboard;
        int                  slots = 1;
        int                  running = 0;
        bit                  held [QUEUE_DEPTH];
        logic [TAG_BITS-1:0] held_tag [QUEUE_DEPTH];
        logic [2:0]          held_cls [QUEUE_DEPTH];
        logic [31:0]         held_dl [QUEUE_DEPTH];
        grant_rec_t          expected [$];
        int                  errors = 0;

        task report(string what);
            errors++;
            $display("[%0t] mismatch: %s", $time, what);
        endtask

        function void set_slots(int value);
            slots = value;
        endfunction

        function logic [2:0] rank(logic hi, logic last, logic dly);
            if (hi)
                return last ? (dly ? CLS_HI_LAST_DLY : CLS_HI_LAST)
                            : (dly ? CLS_HI_DLY : CLS_HI_OTHER);
            if (last && dly)
                return CLS_LO_LAST_DLY;
            return dly ? CLS_LO_DLY : (last ? CLS_LO_LAST : CLS_LO_OTHER);
        endfunction

        function int waiting_total();
            int i;
            int n;
            n = 0;
            for (i = 0; i < QUEUE_DEPTH; i++)
                if (held[i])
                    n++;
            return n;
        endfunction

        function void note_event(logic c, logic [7:0] id, logic hi, logic last, logic dly,
                                 logic [31:0] dl);
            grant_rec_t r;
            int         i;
            int         slot;
            int         head;
            r = '0;
            r.status = ST_OK;
            if (c == CMD_RELEASE)
            begin
                if (running < slots && waiting_total() == 0)
                begin
                    running++;
                    r.grant_valid = 1'b1;
                    r.grant_id = 8'(id[TAG_BITS-1:0]);
                end
                else
                begin
                    slot = -1;
                    for (i = QUEUE_DEPTH - 1; i >= 0; i--)
                        if (!held[i])
                            slot = i;
                    if (slot < 0)
                        r.status = ST_FULL;
                    else
                    begin
                        held[slot] = 1'b1;
                        held_tag[slot] = id[TAG_BITS-1:0];
                        held_cls[slot] = rank(hi, last, dly);
                        held_dl[slot] = dl;
                    end
                end
            end
            else if (running > 0)
                running--;
            else
                r.status = ST_FIN_NONE;

            if (!r.grant_valid && running < slots)
            begin
                head = -1;
                for (i = 0; i < QUEUE_DEPTH; i++)
                    if (held[i] && (head < 0 || held_cls[i] < held_cls[head] ||
                        (held_cls[i] == held_cls[head] && held_dl[i] < held_dl[head])))
                        head = i;
                if (head >= 0)
                begin
                    held[head] = 1'b0;
                    running++;
                    r.grant_valid = 1'b1;
                    r.grant_id = 8'(held_tag[head]);
                end
            end
            r.queued_count = 5'(waiting_total());
            expected.insert(expected.size(), r);
        endfunction

        task check_result(logic gv, logic [7:0] gid, logic [1:0] st, logic [4:0] qc);
            grant_rec_t want;
            if (expected.size() == 0)
            begin
                report($sformatf("result beat with nothing expected (grant %0b id %0d)", gv, gid));
                return;
            end
            want = expected.pop_front();
            if (gv !== want.grant_valid)
                report($sformatf("grant_valid %0b, expected %0b", gv, want.grant_valid));
            if (gid !== want.grant_id)
                report($sformatf("grant_id %0d, expected %0d", gid, want.grant_id));
            if (st !== want.status)
                report($sformatf("status %0d, expected %0d", st, want.status));
            if (qc !== want.queued_count)
                report($sformatf("queued_count %0d, expected %0d", qc, want.queued_count));
        endtask
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        cmd = CMD_RELEASE;
    logic [7:0]  op_id = '0;
    logic        high_priority = 1'b0;
    logic        is_last = 1'b0;
    logic        prior_delayed = 1'b0;
    logic [31:0] deadline = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        grant_valid;
    logic [7:0]  grant_id;
    logic [1:0]  status;
    logic [4:0]  queued_count;

    grant_scoreboard sb;
    int              stall_mode = 1;
    int              stall_run = 0;
    int              cycle_count = 0;

    class_edf_admission_scheduler_core u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .cmd           (cmd),
        .op_id         (op_id),
        .high_priority (high_priority),
        .is_last       (is_last),
        .prior_delayed (prior_delayed),
        .deadline      (deadline),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .grant_valid   (grant_valid),
        .grant_id      (grant_id),
        .status        (status),
        .queued_count  (queued_count)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // receiver stall pattern
    always @(posedge clk)
    begin
        case (stall_mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 2) == 0);
            default:
            begin
                if (stall_run == 0)
                begin
                    out_stall <= ~out_stall;
                    stall_run <= $urandom_range(1, 40);
                end
                else
                    stall_run <= stall_run - 1;
            end
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result(grant_valid, grant_id, status, queued_count);
    end

    task automatic issue(input logic c, input logic [7:0] id, input logic hi,
                         input logic last, input logic dly, input logic [31:0] dl);
        in_valid <= 1'b1;
        cmd <= c;
        op_id <= id;
        high_priority <= hi;
        is_last <= last;
        prior_delayed <= dly;
        deadline <= dl;
        do @(posedge clk); while (in_stall);
        sb.note_event(c, id, hi, last, dly, dl);
    endtask

    task automatic issue_random(input int release_pct);
        logic [31:0] dl;
        case ($urandom_range(0, 3))
            0: dl = 32'($urandom_range(0, 7));
            1: dl = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'd0;
            default: dl = $urandom;
        endcase
        issue(($urandom_range(1, 100) <= release_pct) ? CMD_RELEASE : CMD_FINISH,
              8'($urandom), 1'($urandom), 1'($urandom), 1'($urandom), dl);
    endtask

    task automatic pause(input int cycles);
        in_valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (sb.expected.size() != 0)
            @(posedge clk);
        repeat (QUEUE_DEPTH + 8) @(posedge clk);
    endtask

    task automatic write_max_running(input logic [5:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_MAX_RUNNING;
        pwdata <= {26'd0, value};
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        sb.set_slots(value);
    endtask

    initial
    begin
        int burst;
        int pct;
        bit steady;
        sb = new;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // one slot after reset: finish on empty, direct grant, every class queued
        issue(CMD_FINISH, 8'hA5, 1'b1, 1'b1, 1'b1, 32'hFFFF_FFFF);
        issue(CMD_RELEASE, 8'h00, 1'b0, 1'b0, 1'b0, 32'd0);
        issue(CMD_RELEASE, 8'hFF, 1'b1, 1'b1, 1'b1, 32'hFFFF_FFFF);
        issue(CMD_RELEASE, 8'h11, 1'b1, 1'b1, 1'b0, 32'd5);
        issue(CMD_RELEASE, 8'h12, 1'b1, 1'b0, 1'b1, 32'd5);
        issue(CMD_RELEASE, 8'h13, 1'b1, 1'b0, 1'b0, 32'd5);
        issue(CMD_RELEASE, 8'h14, 1'b0, 1'b1, 1'b1, 32'd0);
        issue(CMD_RELEASE, 8'h15, 1'b0, 1'b0, 1'b1, 32'd7);
        issue(CMD_RELEASE, 8'h16, 1'b0, 1'b1, 1'b0, 32'd7);
        issue(CMD_RELEASE, 8'h17, 1'b0, 1'b0, 1'b0, 32'hFFFF_FFFF);
        issue(CMD_RELEASE, 8'h18, 1'b0, 1'b0, 1'b0, 32'hFFFF_FFFF);
        issue(CMD_RELEASE, 8'h19, 1'b1, 1'b1, 1'b1, 32'd0);
        repeat (11) issue(CMD_FINISH, 8'h00, 1'b0, 1'b0, 1'b0, 32'd0);

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            settle();
            write_max_running(6'(SLOT_PLAN[p]));
            stall_mode = p % 3;
            pct = $urandom_range(35, 90);
            steady = (p % 4 == 1);
            burst = 0;
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (burst == 0)
                begin
                    burst = $urandom_range(1, 12);
                    if (!steady)
                        pause($urandom_range(1, 30));
                end
                issue_random(pct);
                burst--;
            end
        end

        settle();
        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
